// ===== sv/igs_uniform_quantizer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// IGS quantizer assertion macros
// Concurrent assertion helpers for the quantizer top-level RTL.
// ---------------------------------------------------------------------------
`ifndef IGS_UNIFORM_QUANTIZER_UNIT_ASSERT_SVH
`define IGS_UNIFORM_QUANTIZER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IGSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IGSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/igsq_pkg.sv =====
// ---------------------------------------------------------------------------
// IGS quantizer package
// Shared widths, register indexes, engine control types and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package igsq_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned LevelsW = SampleW + 1;
  localparam int unsigned IndexW  = 2;

  localparam logic [LevelsW-1:0] FullScale = LevelsW'(1 << SampleW);

  // configuration register indexes
  localparam logic [IndexW-1:0] RegMode   = 2'd0;
  localparam logic [IndexW-1:0] RegLevels = 2'd1;

  typedef enum logic {
    IGSQ_OP_UNIFORM = 1'b0,
    IGSQ_OP_IGS     = 1'b1
  } igsq_op_e;

  typedef struct packed {
    logic     start;
    logic     ack;
    igsq_op_e op;
  } igsq_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } igsq_status_t;

  // zero levels acts as one level, anything above full scale saturates
  function automatic logic [LevelsW-1:0] eff_levels(input logic [LevelsW-1:0] l);
    logic [LevelsW-1:0] r;
    r = l;
    if (l == '0) begin
      r = LevelsW'(1);
    end else if (l > FullScale) begin
      r = FullScale;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/igs_uniform_quantizer_unit.sv =====
// ---------------------------------------------------------------------------
// IGS / uniform quantizer
// Maps 8-bit samples to level indexes, with optional carried remainder.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) moves one sample plus a first flag
//   per transaction; output channel (out_valid_o/out_ready_i) moves one level.
//   Config channel (cfg_valid_i/cfg_ready_o) writes mode (index 0) or levels
//   (index 1); other indexes are dropped. Write only while the block is idle.
//   Each sample runs in a bit-serial engine (one multiplier bit in uniform
//   mode, one quotient bit in IGS mode), then moves to the output register;
//   a new sample is taken only once the engine has passed the last one on.
//   In IGS mode the carry of one sample feeds the next. A levels write
//   recomputes the IGS divisor serially, with the input channel held off
//   meanwhile.
//   Reset: mode uniform, levels 256, divisor 1, carry 0, nothing in flight.
//   Receiver stall: the output register holds its level; the engine keeps
//   its finished result and no new sample is taken until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module igs_uniform_quantizer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [igsq_pkg::IndexW-1:0]  cfg_index_i,
  input  wire logic [igsq_pkg::LevelsW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [igsq_pkg::SampleW-1:0] sample_i,
  input  wire logic                         first_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [igsq_pkg::SampleW-1:0] level_o
);
  import igsq_pkg::*;

  igsq_op_e            mode_q, mode_d;
  logic [LevelsW-1:0]  levels_q, levels_d;
  logic [SampleW-1:0]  carry_q, carry_d;
  logic                out_valid_q, out_valid_d;
  logic [SampleW-1:0]  level_q, level_d;

  logic                cfg_fire, in_fire, out_load;
  logic                div_start, div_busy;
  logic [LevelsW-1:0]  divisor;
  logic [SampleW-1:0]  carry_eff;
  logic [SampleW:0]    sum;
  logic [SampleW-1:0]  sum_sat;
  logic [SampleW-1:0]  opnd_a;
  logic [LevelsW-1:0]  opnd_b;
  logic [SampleW-1:0]  eng_level, eng_rem;
  igsq_cmd_t           eng_cmd;
  igsq_status_t        eng_st;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign div_start   = cfg_fire && (cfg_index_i == RegLevels);

  assign in_ready_o = !eng_st.busy && !div_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = eng_st.done && (!out_valid_q || out_ready_i);

  // first-of-image drops the carry before the sample is used
  assign carry_eff = first_i ? '0 : carry_q;
  assign sum       = {1'b0, sample_i} + {1'b0, carry_eff};
  assign sum_sat   = sum[SampleW] ? '1 : sum[SampleW-1:0];

  assign opnd_a = (mode_q == IGSQ_OP_IGS) ? sum_sat : sample_i;
  assign opnd_b = (mode_q == IGSQ_OP_IGS) ? divisor : eff_levels(levels_q);

  assign eng_cmd.start = in_fire;
  assign eng_cmd.ack   = out_load;
  assign eng_cmd.op    = mode_q;

  igsq_divisor u_divisor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .levels_i  (eff_levels(cfg_data_i)),
    .busy_o    (div_busy),
    .divisor_o (divisor)
  );

  igsq_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (eng_cmd),
    .opnd_a_i (opnd_a),
    .opnd_b_i (opnd_b),
    .status_o (eng_st),
    .level_o  (eng_level),
    .rem_o    (eng_rem)
  );

  always_comb begin
    mode_d      = mode_q;
    levels_d    = levels_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        RegMode:   mode_d   = igsq_op_e'(cfg_data_i[0]);
        RegLevels: levels_d = cfg_data_i;
        default:   ;
      endcase
    end
    if (in_fire && first_i) begin
      carry_d = '0;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      level_d     = eng_level;
      if (mode_q == IGSQ_OP_IGS) begin
        carry_d = eng_rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= IGSQ_OP_UNIFORM;
      levels_q    <= FullScale;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      levels_q    <= levels_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

`include "igs_uniform_quantizer_unit_assert.svh"

  `IGSQ_ASSERT_NXT(a_start_busy, in_fire, eng_st.busy, "accepted sample did not start engine")
  `IGSQ_ASSERT_IMP(a_div_nonzero, !div_busy, divisor != '0, "IGS divisor is zero")
  `IGSQ_ASSERT_IMP(a_rem_below_div, out_load && (mode_q == IGSQ_OP_IGS),
                   {1'b0, eng_rem} < divisor, "IGS remainder not below divisor")
  `IGSQ_ASSERT_IMP(a_no_start_during_div, div_busy, !in_fire, "sample taken during divisor update")

endmodule

`default_nettype wire

// ===== sv/igsq_divisor.sv =====
// ---------------------------------------------------------------------------
// IGS divisor unit
// Bit-serial restoring division of full scale by the level count.
// ---------------------------------------------------------------------------
`default_nettype none

module igsq_divisor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [igsq_pkg::LevelsW-1:0] levels_i,
  output logic                              busy_o,
  output logic      [igsq_pkg::LevelsW-1:0] divisor_o
);
  import igsq_pkg::*;

  localparam int unsigned CntW = $clog2(LevelsW);
  localparam logic [CntW-1:0] LastStep = CntW'(LevelsW - 1);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [LevelsW-1:0]  den_q, den_d;
  logic [LevelsW-1:0]  rem_q, rem_d;
  logic [LevelsW-1:0]  quo_q, quo_d;
  logic [LevelsW-1:0]  div_q, div_d;
  logic [LevelsW-1:0]  trial;
  logic                fit;

  // dividend is full scale: only its top bit is set, fed on the first step
  assign trial = {rem_q[LevelsW-2:0], (cnt_q == '0)};
  assign fit   = (trial >= den_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = levels_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fit ? (trial - den_q) : trial;
      quo_d = {quo_q[LevelsW-2:0], fit};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        div_d  = {quo_q[LevelsW-2:0], fit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= LevelsW'(1);   // full-scale levels after reset
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o    = busy_q;
  assign divisor_o = div_q;

endmodule

`default_nettype wire

// ===== sv/igsq_engine.sv =====
// ---------------------------------------------------------------------------
// IGS quantizer engine
// One bit per cycle: shift-add multiply (uniform) or restoring divide (IGS).
// ---------------------------------------------------------------------------
`default_nettype none

module igsq_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire igsq_pkg::igsq_cmd_t          cmd_i,
  input  wire logic [igsq_pkg::SampleW-1:0] opnd_a_i,
  input  wire logic [igsq_pkg::LevelsW-1:0] opnd_b_i,
  output igsq_pkg::igsq_status_t            status_o,
  output logic      [igsq_pkg::SampleW-1:0] level_o,
  output logic      [igsq_pkg::SampleW-1:0] rem_o
);
  import igsq_pkg::*;

  localparam int unsigned CntW = $clog2(SampleW);
  localparam logic [CntW-1:0] LastStep = CntW'(SampleW - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  igsq_op_e            op_q, op_d;
  logic [SampleW-1:0]  sh_q, sh_d;
  logic [LevelsW-1:0]  acc_q, acc_d;
  logic [SampleW-1:0]  quo_q, quo_d;
  logic [LevelsW-1:0]  opnd_q, opnd_d;

  logic [LevelsW:0]    mul_sum;
  logic [LevelsW-1:0]  div_trial;
  logic                div_fit;

  // multiply: add operand when the low multiplier bit is set, then shift right
  assign mul_sum   = {1'b0, acc_q} + (sh_q[0] ? {1'b0, opnd_q} : '0);
  // divide: remainder stays below the divisor, so its low bits shift up
  assign div_trial = {acc_q[SampleW-1:0], sh_q[SampleW-1]};
  assign div_fit   = (div_trial >= opnd_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    sh_d    = sh_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    opnd_d  = opnd_q;
    case (state_q)
      StIdle: begin
        if (cmd_i.start) begin
          state_d = StRun;
          cnt_d   = '0;
          op_d    = cmd_i.op;
          sh_d    = opnd_a_i;
          acc_d   = '0;
          quo_d   = '0;
          opnd_d  = opnd_b_i;
        end
      end
      StRun: begin
        if (op_q == IGSQ_OP_UNIFORM) begin
          acc_d = mul_sum[LevelsW:1];
          sh_d  = {1'b0, sh_q[SampleW-1:1]};
        end else begin
          acc_d = div_fit ? (div_trial - opnd_q) : div_trial;
          quo_d = {quo_q[SampleW-2:0], div_fit};
          sh_d  = {sh_q[SampleW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (cmd_i.ack) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    opnd_q <= opnd_d;
  end

  assign status_o.busy = (state_q != StIdle);
  assign status_o.done = (state_q == StDone);
  assign level_o = (op_q == IGSQ_OP_UNIFORM) ? acc_q[SampleW-1:0] : quo_q;
  assign rem_o   = acc_q[SampleW-1:0];

endmodule

`default_nettype wire
